// ===== hw/rtl/qgi_pkg.sv =====
// Shared types, constants and step tables of the quaternion gyro integrator.
package qgi_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_X        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Y        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Z        = 2'd3;

    localparam logic [31:0] PERIOD_RESET = 32'd4294967;

    localparam logic [4:0] DQ_STEPS   = 5'd3;
    localparam logic [4:0] TERM_LAST  = 5'd14;
    localparam logic [4:0] SQ_FIRST   = 5'd15;
    localparam logic [4:0] MUL_STEPS  = 5'd19;
    localparam logic [4:0] SQRT_ITERS = 5'd31;
    localparam logic [4:0] DIV_ITERS  = 5'd31;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SQINIT,
        S_SQRT,
        S_DSETUP,
        S_DIV,
        S_DWRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [4:0] step;
        logic       sq_init;
        logic       sq_en;
        logic       dv_setup;
        logic       dv_en;
        logic       dv_write;
        logic [1:0] comp;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] qsel;
        logic [1:0] dsel;
        logic [1:0] dest;
        logic       neg;
    } t_term;

    function automatic t_term term_of(input logic [4:0] step);
        t_term t;
        case (step)
            5'd3:    t = '{qsel: 2'd1, dsel: 2'd0, dest: 2'd0, neg: 1'b1};
            5'd4:    t = '{qsel: 2'd2, dsel: 2'd1, dest: 2'd0, neg: 1'b1};
            5'd5:    t = '{qsel: 2'd3, dsel: 2'd2, dest: 2'd0, neg: 1'b1};
            5'd6:    t = '{qsel: 2'd0, dsel: 2'd0, dest: 2'd1, neg: 1'b0};
            5'd7:    t = '{qsel: 2'd2, dsel: 2'd2, dest: 2'd1, neg: 1'b0};
            5'd8:    t = '{qsel: 2'd3, dsel: 2'd1, dest: 2'd1, neg: 1'b1};
            5'd9:    t = '{qsel: 2'd0, dsel: 2'd1, dest: 2'd2, neg: 1'b0};
            5'd10:   t = '{qsel: 2'd1, dsel: 2'd2, dest: 2'd2, neg: 1'b1};
            5'd11:   t = '{qsel: 2'd3, dsel: 2'd0, dest: 2'd2, neg: 1'b0};
            5'd12:   t = '{qsel: 2'd0, dsel: 2'd2, dest: 2'd3, neg: 1'b0};
            5'd13:   t = '{qsel: 2'd1, dsel: 2'd1, dest: 2'd3, neg: 1'b0};
            5'd14:   t = '{qsel: 2'd2, dsel: 2'd0, dest: 2'd3, neg: 1'b1};
            default: t = '{qsel: 2'd0, dsel: 2'd0, dest: 2'd0, neg: 1'b0};
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/qgi_ctrl.sv =====
// Sequencer of the quaternion gyro integrator: step counters and handshakes.
module qgi_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output qgi_pkg::t_dp_cmd o_cmd
);
    import qgi_pkg::*;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_comp, n_comp;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_comp      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_comp      <= n_comp;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_comp      = r_comp;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.step  = r_cnt;
        o_cmd.comp  = r_comp;
        o_in_stall  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = (r_cnt != MUL_STEPS);
                n_cnt        = r_cnt + 5'd1;
                if (r_cnt == MUL_STEPS) begin
                    n_state = S_SQINIT;
                end
            end
            S_SQINIT: begin
                o_cmd.sq_init = 1'b1;
                n_cnt         = '0;
                n_state       = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sq_en = 1'b1;
                n_cnt       = r_cnt + 5'd1;
                if (r_cnt == SQRT_ITERS) begin
                    n_comp  = '0;
                    n_state = S_DSETUP;
                end
            end
            S_DSETUP: begin
                o_cmd.dv_setup = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.dv_en = 1'b1;
                n_cnt       = r_cnt + 5'd1;
                if (r_cnt == DIV_ITERS) begin
                    n_state = S_DWRITE;
                end
            end
            S_DWRITE: begin
                o_cmd.dv_write = 1'b1;
                n_comp         = r_comp + 2'd1;
                n_state        = (r_comp == 2'd3) ? S_DONE : S_DSETUP;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/qgi_dp.sv =====
// Datapath of the quaternion gyro integrator: multiplier, square root, divider.
module qgi_dp #(
    parameter int QUAT_FRAC_BITS = 30
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  qgi_pkg::t_dp_cmd                 i_cmd,
    input  logic                             i_cfg_we,
    input  logic [qgi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                      i_cfg_data,
    input  logic signed [31:0]               i_rate_x,
    input  logic signed [31:0]               i_rate_y,
    input  logic signed [31:0]               i_rate_z,
    output logic signed [31:0]               o_quat_w,
    output logic signed [31:0]               o_quat_i,
    output logic signed [31:0]               o_quat_j,
    output logic signed [31:0]               o_quat_k
);
    import qgi_pkg::*;

    localparam int SH_DQ = 57 - QUAT_FRAC_BITS;
    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< QUAT_FRAC_BITS;
    localparam logic signed [65:0] MAX66 = 66'sd2147483647;
    localparam logic signed [65:0] MIN66 = -66'sd2147483648;

    function automatic logic signed [65:0] rnd(input logic signed [65:0] v, input int s);
        logic [65:0] m;
        logic [65:0] r;
        m = v[65] ? 66'(-v) : 66'(v);
        r = (m + (66'd1 << (s - 1))) >> s;
        return v[65] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > MAX66) begin
            return 32'sh7FFFFFFF;
        end else if (v < MIN66) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31]) begin
            return d[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        return d[31:0];
    endfunction

    logic        [31:0] r_period;
    logic signed [31:0] r_bias [3];
    logic signed [31:0] r_att  [4];
    logic signed [31:0] r_gb   [3];
    logic signed [31:0] r_dq   [3];
    logic signed [65:0] r_acc  [4];
    logic signed [31:0] r_nq   [4];
    logic signed [31:0] r_out  [4];
    logic signed [65:0] r_prod;
    logic [4:0]         r_pstep;
    logic               r_pvalid;
    logic [64:0]        r_ssum;
    logic [63:0]        r_x;
    logic [35:0]        r_rem;
    logic [31:0]        r_root;
    logic [31:0]        r_drem;
    logic [31:0]        r_dlow;
    logic [31:0]        r_quo;
    logic               r_dneg;
    logic               r_dovf;

    logic signed [31:0] n_sat [4];
    logic signed [32:0] op_a, op_b;
    t_term              t_iss, t_ret;
    logic [4:0]         sq_idx;
    logic signed [65:0] term;
    logic [35:0]        rem4;
    logic [33:0]        trial;
    logic               sq_ge;
    logic signed [31:0] dn;
    logic [31:0]        dmag;
    logic [63:0]        dnum;
    logic [32:0]        drem2;
    logic               dv_ge;
    logic signed [31:0] dres;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_sat[k] = sat32(r_acc[k]);
        end
    end

    assign t_iss  = term_of(i_cmd.step);
    assign t_ret  = term_of(r_pstep);
    assign sq_idx = i_cmd.step - SQ_FIRST;

    always_comb begin
        if (i_cmd.step < DQ_STEPS) begin
            op_a = {r_gb[i_cmd.step[1:0]][31], r_gb[i_cmd.step[1:0]]};
            op_b = {1'b0, r_period};
        end else if (i_cmd.step <= TERM_LAST) begin
            op_a = {r_att[t_iss.qsel][31], r_att[t_iss.qsel]};
            op_b = {r_dq[t_iss.dsel][31], r_dq[t_iss.dsel]};
        end else begin
            op_a = {n_sat[sq_idx[1:0]][31], n_sat[sq_idx[1:0]]};
            op_b = op_a;
        end
    end

    assign term  = rnd(r_prod, QUAT_FRAC_BITS);
    assign rem4  = {r_rem[33:0], r_x[63:62]};
    assign trial = {r_root, 2'b01};
    assign sq_ge = rem4 >= {2'b00, trial};

    assign dn    = n_sat[i_cmd.comp];
    assign dmag  = dn[31] ? 32'(-{dn[31], dn}) : 32'(dn);
    assign dnum  = ({32'd0, dmag} << QUAT_FRAC_BITS) + {33'd0, r_root[31:1]};
    assign drem2 = {r_drem, r_dlow[31]};
    assign dv_ge = drem2 >= {1'b0, r_root};

    always_comb begin
        if (r_dneg) begin
            dres = (r_dovf || r_quo > 32'h80000000) ? 32'sh80000000 : -$signed(r_quo);
        end else begin
            dres = (r_dovf || r_quo > 32'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(r_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_bias   <= '{default: '0};
            r_att    <= '{ONE_Q, 32'sd0, 32'sd0, 32'sd0};
            r_pvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SAMPLE_PERIOD: r_period <= i_cfg_data;
                    CFG_BIAS_X:        r_bias[0] <= i_cfg_data;
                    CFG_BIAS_Y:        r_bias[1] <= i_cfg_data;
                    CFG_BIAS_Z:        r_bias[2] <= i_cfg_data;
                    default:           r_period <= r_period;
                endcase
            end
            r_pvalid <= i_cmd.mul_en;
            if (i_cmd.out_load) begin
                if (r_root == '0) begin
                    r_att <= '{ONE_Q, 32'sd0, 32'sd0, 32'sd0};
                end else begin
                    r_att <= r_nq;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_gb[0] <= sub_sat(i_rate_x, r_bias[0]);
            r_gb[1] <= sub_sat(i_rate_y, r_bias[1]);
            r_gb[2] <= sub_sat(i_rate_z, r_bias[2]);
            for (int k = 0; k < 4; k++) begin
                r_acc[k] <= 66'(r_att[k]);
            end
            r_ssum <= '0;
        end
        if (i_cmd.mul_en) begin
            r_prod  <= op_a * op_b;
            r_pstep <= i_cmd.step;
        end
        if (r_pvalid) begin
            if (r_pstep < DQ_STEPS) begin
                r_dq[r_pstep[1:0]] <= sat32(rnd(r_prod, SH_DQ));
            end else if (r_pstep <= TERM_LAST) begin
                r_acc[t_ret.dest] <= t_ret.neg ? r_acc[t_ret.dest] - term
                                               : r_acc[t_ret.dest] + term;
            end else begin
                r_ssum <= r_ssum + {1'b0, r_prod[63:0]};
            end
        end
        if (i_cmd.sq_init) begin
            r_x    <= r_ssum[64] ? '1 : r_ssum[63:0];
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.sq_en) begin
            r_x    <= {r_x[61:0], 2'b00};
            r_rem  <= sq_ge ? rem4 - {2'b00, trial} : rem4;
            r_root <= {r_root[30:0], sq_ge};
        end
        if (i_cmd.dv_setup) begin
            r_dneg <= dn[31];
            r_dovf <= dnum >= {r_root, 32'd0};
            r_drem <= dnum[63:32];
            r_dlow <= dnum[31:0];
            r_quo  <= '0;
        end
        if (i_cmd.dv_en) begin
            r_drem <= dv_ge ? 32'(drem2 - {1'b0, r_root}) : drem2[31:0];
            r_dlow <= {r_dlow[30:0], 1'b0};
            r_quo  <= {r_quo[30:0], dv_ge};
        end
        if (i_cmd.dv_write) begin
            r_nq[i_cmd.comp] <= dres;
        end
        if (i_cmd.out_load) begin
            if (r_root == '0) begin
                r_out <= '{ONE_Q, 32'sd0, 32'sd0, 32'sd0};
            end else begin
                r_out <= r_nq;
            end
        end
    end

    assign o_quat_w = r_out[0];
    assign o_quat_i = r_out[1];
    assign o_quat_j = r_out[2];
    assign o_quat_k = r_out[3];

endmodule

// ===== hw/rtl/quaternion_gyro_integrator.sv =====
// Top level of the quaternion gyro integrator: sequencer plus datapath.
//
//   channel | direction | handshake             | payload
//   in      | input     | i_in_valid/o_in_stall | i_rate_x, i_rate_y, i_rate_z
//   out     | output    | o_out_valid/i_out_stall | o_quat_w, o_quat_i, o_quat_j, o_quat_k
//   cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item occupies the block until its result is loaded: it is accepted and loaded,
// makes its pass through the shared 33x33 multiplier, then the 2-bit-per-cycle square
// root and four 1-bit-per-cycle divisions, and then the result is loaded; no new item
// is accepted in that time. Reset sets the attitude to identity and the registers to
// their defaults. A held result stalls only the final output load; the next item
// is taken while the result waits.
module quaternion_gyro_integrator #(
    parameter int QUAT_FRAC_BITS = 30
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [31:0]            i_rate_x,
    input  logic signed [31:0]            i_rate_y,
    input  logic signed [31:0]            i_rate_z,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [31:0]            o_quat_w,
    output logic signed [31:0]            o_quat_i,
    output logic signed [31:0]            o_quat_j,
    output logic signed [31:0]            o_quat_k,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [qgi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import qgi_pkg::*;

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    qgi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    qgi_dp #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rate_x    (i_rate_x),
        .i_rate_y    (i_rate_y),
        .i_rate_z    (i_rate_z),
        .o_quat_w    (o_quat_w),
        .o_quat_i    (o_quat_i),
        .o_quat_j    (o_quat_j),
        .o_quat_k    (o_quat_k)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in work");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result load over a held item");

    a_single_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({cmd.load, cmd.mul_en, cmd.sq_en, cmd.dv_en, cmd.out_load}) <= 1)
        else $error("datapath commands overlap");

endmodule
